// File: hw/rtl/slcg_pkg.sv
// Package for the shuffled LCG random generator.
// Holds field widths, LCG constants, the modulus reciprocal and the
// command and status structs shared by the controller and the datapath.
package slcg_pkg;

  localparam int unsigned ValW       = 20;  // LCG values and results
  localparam int unsigned SeedW      = 18;  // start seed register
  localparam int unsigned ProdW      = 30;  // a*x + c before reduction
  localparam int unsigned QuoW       = 11;  // quotient of ProdW by the modulus
  localparam int unsigned RecipShift = 40;
  localparam int unsigned RecipW     = 21;

  localparam logic [ValW-1:0]  LcgM      = 20'd714025;
  localparam int unsigned      LcgA      = 1366;
  localparam logic [ValW-1:0]  LcgC      = 20'd150889;
  localparam logic [SeedW-1:0] SeedReset = 18'd54813;

  // floor(2^RecipShift / M): the quotient estimate is low by at most one.
  localparam logic [RecipW-1:0] LcgRecip =
      RecipW'((64'd1 << RecipShift) / 64'd714025);

  typedef struct packed {
    logic init_seed;      // seed <- start value
    logic cnt_clear;      // fill counter to zero
    logic fill_write;     // table[cnt] <- lcg, seed <- lcg, cnt++
    logic last_from_lcg;  // last <- lcg, seed <- lcg
    logic idx_latch;      // hold index, read table at it
    logic last_from_ram;  // last <- table read data
    logic draw_commit;    // table[idx] <- lcg, seed <- lcg, load outputs
  } slcg_cmd_t;

  typedef struct packed {
    logic fill_end;       // counter has reached the table depth
  } slcg_status_t;

endpackage

// File: hw/rtl/slcg_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; contents are undefined until written.
module slcg_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 97
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/slcg_modred.sv
// Two-stage reduction of a product-sum by the LCG modulus.
// Uses slcg_pkg for widths, the modulus and its reciprocal.
module slcg_modred (
  input  logic                        clk_i,
  input  logic [slcg_pkg::ProdW-1:0]  x_i,
  output logic [slcg_pkg::QuoW-1:0]   quo_o,
  output logic [slcg_pkg::ValW-1:0]   rem_o
);

  localparam int unsigned PW = slcg_pkg::ProdW + slcg_pkg::RecipW;

  logic [slcg_pkg::ProdW-1:0] x_q;
  logic [slcg_pkg::ProdW-1:0] x1_q;
  logic [PW-1:0]              p_q;
  logic [slcg_pkg::QuoW-1:0]  q_est;
  logic [slcg_pkg::ProdW-1:0] qm;
  logic [slcg_pkg::ValW:0]    r0;

  // Free running: the operand, then the reciprocal product, are registered.
  always_ff @(posedge clk_i) begin
    x_q  <= x_i;
    x1_q <= x_q;
    p_q  <= PW'(x_q) * PW'(slcg_pkg::LcgRecip);
  end

  always_comb begin
    q_est = p_q[slcg_pkg::RecipShift +: slcg_pkg::QuoW];
    qm    = slcg_pkg::ProdW'(slcg_pkg::ProdW'(q_est) * slcg_pkg::ProdW'(slcg_pkg::LcgM));
    // The estimate may be one short, leaving a remainder below twice the modulus.
    r0    = (slcg_pkg::ValW + 1)'(x1_q - qm);
    if (r0 >= (slcg_pkg::ValW + 1)'(slcg_pkg::LcgM)) begin
      rem_o = slcg_pkg::ValW'(r0 - (slcg_pkg::ValW + 1)'(slcg_pkg::LcgM));
      quo_o = q_est + slcg_pkg::QuoW'(1);
    end else begin
      rem_o = slcg_pkg::ValW'(r0);
      quo_o = q_est;
    end
  end

endmodule

// File: hw/rtl/slcg_datapath.sv
// Datapath: start seed register, LCG and index reduction units, shuffle
// table RAM, fill counter and result registers. Uses slcg_pkg, slcg_modred, slcg_ram.
module slcg_datapath #(
  parameter int unsigned TableDepth = 97
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [slcg_pkg::SeedW-1:0]  cfg_wdata_i,
  input  slcg_pkg::slcg_cmd_t         cmd_i,
  output slcg_pkg::slcg_status_t      status_o,
  output logic [slcg_pkg::ValW-1:0]   deviate_o,
  output logic [slcg_pkg::ValW-1:0]   seed_now_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned VW   = slcg_pkg::ValW;
  localparam int unsigned XW   = slcg_pkg::ProdW;

  logic [slcg_pkg::SeedW-1:0] start_seed_q;
  logic [VW-1:0]              seed_q, last_q, deviate_q, seed_now_q;
  logic [IdxW-1:0]            idx_q;
  logic [CntW-1:0]            cnt_q;

  logic [XW-1:0]              lcg_x, idx_x;
  logic [slcg_pkg::QuoW-1:0]  lcg_quo, idx_quo;
  logic [VW-1:0]              lcg_rem, idx_rem;
  logic [IdxW-1:0]            idx_now, ram_addr;
  logic [VW-1:0]              ram_rdata;
  logic [slcg_pkg::SeedW-1:0] seed_nz;
  logic [VW-1:0]              seed_init;

  assign lcg_x   = XW'(XW'(slcg_pkg::LcgA) * XW'(seed_q)) + XW'(slcg_pkg::LcgC);
  assign idx_x   = XW'(XW'(TableDepth) * XW'(last_q));
  assign idx_now = idx_quo[IdxW-1:0];

  slcg_modred u_lcg (
    .clk_i (clk_i),
    .x_i   (lcg_x),
    .quo_o (lcg_quo),
    .rem_o (lcg_rem)
  );

  slcg_modred u_index (
    .clk_i (clk_i),
    .x_i   (idx_x),
    .quo_o (idx_quo),
    .rem_o (idx_rem)
  );

  always_comb begin
    if (cmd_i.fill_write) begin
      ram_addr = cnt_q[IdxW-1:0];
    end else if (cmd_i.draw_commit) begin
      ram_addr = idx_q;
    end else begin
      ram_addr = idx_now;
    end
  end

  slcg_ram #(
    .Width (VW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (cmd_i.fill_write | cmd_i.draw_commit),
    .wdata_i (lcg_rem),
    .rdata_o (ram_rdata)
  );

  // A zero start seed counts as one; the offset from the increment is taken
  // as a magnitude.
  always_comb begin
    seed_nz = (start_seed_q == '0) ? slcg_pkg::SeedW'(1) : start_seed_q;
    if (VW'(seed_nz) <= slcg_pkg::LcgC) begin
      seed_init = slcg_pkg::LcgC - VW'(seed_nz);
    end else begin
      seed_init = VW'(seed_nz) - slcg_pkg::LcgC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_seed_q <= slcg_pkg::SeedReset;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        start_seed_q <= cfg_wdata_i;
      end
      if (cmd_i.cnt_clear) begin
        cnt_q <= '0;
      end else if (cmd_i.fill_write) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_seed) begin
      seed_q <= seed_init;
    end else if (cmd_i.fill_write || cmd_i.last_from_lcg || cmd_i.draw_commit) begin
      seed_q <= lcg_rem;
    end
    if (cmd_i.last_from_lcg) begin
      last_q <= lcg_rem;
    end else if (cmd_i.last_from_ram) begin
      last_q <= ram_rdata;
    end
    if (cmd_i.idx_latch) begin
      idx_q <= idx_now;
    end
    if (cmd_i.draw_commit) begin
      deviate_q  <= last_q;
      seed_now_q <= lcg_rem;
    end
  end

  assign status_o.fill_end = (cnt_q == CntW'(TableDepth));
  assign deviate_o         = deviate_q;
  assign seed_now_o        = seed_now_q;

`ifndef NO_ASSERTIONS
  a_commit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.draw_commit |-> (32'(idx_q) < TableDepth))
    else $error("draw writes back outside the shuffle table");
  a_lcg_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.fill_write || cmd_i.draw_commit) |-> (lcg_rem < slcg_pkg::LcgM))
    else $error("LCG value not reduced below the modulus");
`endif

endmodule

// File: hw/rtl/slcg_ctrl.sv
// Controller state machine for the shuffled LCG generator: table fill on
// first or reseed request, then the draw sequence. Uses slcg_pkg.
module slcg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   reseed_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output slcg_pkg::slcg_cmd_t    cmd_o,
  input  slcg_pkg::slcg_status_t status_i
);

  typedef enum logic [9:0] {
    StIdle = 10'b00_0000_0001,
    StInit = 10'b00_0000_0010,
    StF0   = 10'b00_0000_0100,
    StF1   = 10'b00_0000_1000,
    StF2   = 10'b00_0001_0000,
    StW0   = 10'b00_0010_0000,
    StW1   = 10'b00_0100_0000,
    StD0   = 10'b00_1000_0000,
    StD1   = 10'b01_0000_0000,
    StD2   = 10'b10_0000_0000
  } slcg_state_e;

  slcg_state_e state_q, state_d;
  logic        primed_q, primed_d;
  logic        result_valid_q, result_valid_d;

  always_comb begin
    state_d        = state_q;
    primed_d       = primed_q;
    result_valid_d = 1'b0;
    cmd_o          = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = (reseed_i || !primed_q) ? StInit : StD0;
        end
      end
      StInit: begin
        cmd_o.init_seed = 1'b1;
        cmd_o.cnt_clear = 1'b1;
        state_d         = StF0;
      end
      StF0: state_d = StF1;
      StF1: state_d = StF2;
      StF2: begin
        // One step past the table gives the first last-output value.
        if (status_i.fill_end) begin
          cmd_o.last_from_lcg = 1'b1;
          primed_d            = 1'b1;
          state_d             = StW0;
        end else begin
          cmd_o.fill_write = 1'b1;
          state_d          = StF0;
        end
      end
      // The wait states let the index unit take up the new last-output value.
      StW0: state_d = StW1;
      StW1: state_d = StD0;
      StD0: begin
        cmd_o.idx_latch = 1'b1;
        state_d         = StD1;
      end
      StD1: begin
        cmd_o.last_from_ram = 1'b1;
        state_d             = StD2;
      end
      StD2: begin
        cmd_o.draw_commit = 1'b1;
        result_valid_d    = 1'b1;
        state_d           = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      primed_q       <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      primed_q       <= primed_d;
      result_valid_q <= result_valid_d;
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = result_valid_q;

`ifndef NO_ASSERTIONS
  a_fast_draw_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o && primed_q && !reseed_i) |-> ##4 result_valid_q)
    else $error("draw from a primed table did not finish in four cycles");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
      result_valid_q |=> !result_valid_q)
    else $error("result strobe held for more than one cycle");
  a_draw_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == StD0) |-> primed_q)
    else $error("draw started before the table was filled");
`endif

endmodule

// File: hw/rtl/shuffled_lcg_random_generator_unit.sv
// Top level of the shuffled LCG random generator (97-entry shuffle table).
// Joins slcg_ctrl and slcg_datapath; uses slcg_pkg.
//
//  channel   handshake                ports
//  -------   ----------------------   ----------------------------------
//  request   start & !busy            reseed_i
//  result    result_valid_o strobe    deviate_o, seed_now_o
//  config    cfg_we_i                 cfg_wdata_i (start seed)
//
// A draw from a filled table runs StD0, StD1 and StD2 and then goes idle, ready
// for the next request; the result strobe is registered in StD2. The first
// request after reset, and any request with reseed set, first refills the table
// in TableDepth + 1 LCG steps, each through StF0, StF1 and StF2 for the two-stage
// modulus reduction, between StInit and the wait states StW0 and StW1.
// Reset clears the controller and restores the start seed to its reset value.
// Results are shown for one cycle only; the receiver cannot stall them.
module shuffled_lcg_random_generator_unit #(
  parameter int unsigned TableDepth = 97
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        reseed_i,
  input  logic                        cfg_we_i,
  input  logic [slcg_pkg::SeedW-1:0]  cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [slcg_pkg::ValW-1:0]   deviate_o,
  output logic [slcg_pkg::ValW-1:0]   seed_now_o
);

  slcg_pkg::slcg_cmd_t    cmd;
  slcg_pkg::slcg_status_t status;

  slcg_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .reseed_i       (reseed_i),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  slcg_datapath #(
    .TableDepth (TableDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .deviate_o   (deviate_o),
    .seed_now_o  (seed_now_o)
  );

endmodule

// File: tb/shuffled_lcg_random_generator_unit_tb.sv
// Self-checking testbench for shuffled_lcg_random_generator_unit.
// It predicts each draw of the shuffled LCG from its own table copy and checks
// every result strobe. It depends only on slcg_pkg and the unit itself.
module shuffled_lcg_random_generator_unit_tb;

  localparam int unsigned TableDepth = 97;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 70;
  localparam int unsigned NumPhases = 8;

  typedef struct packed {
    logic [slcg_pkg::ValW-1:0] deviate;
    logic [slcg_pkg::ValW-1:0] seed_now;
  } draw_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        reseed_i = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [slcg_pkg::SeedW-1:0]  cfg_wdata_i = '0;
  logic                        result_valid_o;
  logic [slcg_pkg::ValW-1:0]   deviate_o;
  logic [slcg_pkg::ValW-1:0]   seed_now_o;

  // Copy of the generator state used for prediction.
  logic [slcg_pkg::ValW-1:0]   shuffle_copy [TableDepth];
  logic [slcg_pkg::ValW-1:0]   lcg_copy = '0;
  logic [slcg_pkg::ValW-1:0]   last_copy = '0;
  logic                        table_primed = 1'b0;
  logic [slcg_pkg::SeedW-1:0]  start_seed_copy = slcg_pkg::SeedReset;

  bit                pending_reseed [$];
  draw_result_t      expected_draws [$];
  int unsigned       send_idle_pct = 0;
  int unsigned       items_taken = 0;
  int unsigned       reseeds_taken = 0;
  int unsigned       draws_checked = 0;
  int unsigned       seed_writes = 0;
  int unsigned       errors = 0;
  int unsigned       cycles = 0;

  shuffled_lcg_random_generator_unit #(
    .TableDepth(TableDepth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .reseed_i      (reseed_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .deviate_o     (deviate_o),
    .seed_now_o    (seed_now_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [slcg_pkg::ValW-1:0] lcg_advance(
      input logic [slcg_pkg::ValW-1:0] s);
    logic [63:0] v;
    v = 64'(slcg_pkg::LcgA) * 64'(s) + 64'(slcg_pkg::LcgC);
    return slcg_pkg::ValW'(v % 64'(slcg_pkg::LcgM));
  endfunction

  // Refills the shuffle table from the start seed, as on the first request.
  task automatic refill_table();
    logic [slcg_pkg::ValW-1:0] s;
    s = (start_seed_copy == '0) ? slcg_pkg::ValW'(1) : slcg_pkg::ValW'(start_seed_copy);
    // A start seed above the increment uses the magnitude of the difference.
    if (s <= slcg_pkg::LcgC) s = slcg_pkg::LcgC - s;
    else s = s - slcg_pkg::LcgC;
    for (int k = 0; k < TableDepth; k++) begin
      s = lcg_advance(s);
      shuffle_copy[k] = s;
    end
    s = lcg_advance(s);
    last_copy = s;
    lcg_copy = s;
    table_primed = 1'b1;
  endtask

  task automatic predict_draw(input logic reseed, output draw_result_t res);
    logic [63:0] idx;
    if (reseed || !table_primed) refill_table();
    idx = (64'(TableDepth) * 64'(last_copy % slcg_pkg::LcgM)) / 64'(slcg_pkg::LcgM);
    if (idx >= 64'(TableDepth)) idx = 64'(TableDepth - 1);
    last_copy = shuffle_copy[idx];
    lcg_copy = lcg_advance(lcg_copy % slcg_pkg::LcgM);
    shuffle_copy[idx] = lcg_copy;
    res.deviate = last_copy;
    res.seed_now = lcg_copy;
  endtask

  // Keeps start high until the item is taken, then moves to the next one
  // or idles at random.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic         taken;
    draw_result_t res;
    if (!rst_ni) begin
      start <= 1'b0;
      reseed_i <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        predict_draw(reseed_i, res);
        expected_draws.push_back(res);
        items_taken++;
        if (reseed_i) reseeds_taken++;
      end
      if (start && !taken) begin
        // Hold the item until it is accepted.
      end else if (pending_reseed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        reseed_i <= pending_reseed.pop_front();
      end else begin
        start <= 1'b0;
        reseed_i <= 1'($urandom_range(1));
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    draw_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_draws.size() == 0) begin
        errors++;
        $error("result with none expected: deviate %0d seed_now %0d", deviate_o, seed_now_o);
      end else begin
        want = expected_draws.pop_front();
        draws_checked++;
        if (deviate_o !== want.deviate) begin
          errors++;
          $error("deviate: expected %0d, got %0d", want.deviate, deviate_o);
        end
        if (seed_now_o !== want.seed_now) begin
          errors++;
          $error("seed_now: expected %0d, got %0d", want.seed_now, seed_now_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Returns once every item has been taken, every result checked and the
  // unit has gone idle.
  task automatic wait_drained();
    while (start || pending_reseed.size() != 0 || expected_draws.size() != 0 || busy)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start_seed(input logic [slcg_pkg::SeedW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_seed_copy = value;
    seed_writes++;
  endtask

  initial begin
    logic [slcg_pkg::SeedW-1:0] phase_seeds [NumPhases];
    int unsigned                idle_steps [3];
    phase_seeds = '{18'd0, 18'h3FFFF, 18'd150888, 18'd150889, 18'd1, 18'd150890,
                    slcg_pkg::SeedW'($urandom),
                    slcg_pkg::SeedW'($urandom_range(150888))};
    idle_steps = '{0, 66, 35};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening on the reset seed: the first request carries reseed
    // while the table is still empty, then plain draws and back-to-back reseeds.
    pending_reseed.push_back(1'b1);
    repeat (10) pending_reseed.push_back(1'b0);
    pending_reseed.push_back(1'b1);
    repeat (5) pending_reseed.push_back(1'b0);
    pending_reseed.push_back(1'b1);
    pending_reseed.push_back(1'b1);
    repeat (3) pending_reseed.push_back(1'b0);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      write_start_seed(phase_seeds[p]);
      send_idle_pct = idle_steps[p % 3];
      pending_reseed.push_back(1'b1);
      for (int i = 1; i < ItemsPerPhase; i++)
        pending_reseed.push_back($urandom_range(99) < 5);
      wait_drained();
    end

    $display("Checked %0d draws from %0d items, %0d of them reseeds.",
             draws_checked, items_taken, reseeds_taken);
    $display("Start seed written %0d times, zero, all ones and both sides of the increment.",
             seed_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/slcg_pkg.sv
hw/rtl/slcg_ram.sv
hw/rtl/slcg_modred.sv
hw/rtl/slcg_datapath.sv
hw/rtl/slcg_ctrl.sv
hw/rtl/shuffled_lcg_random_generator_unit.sv
tb/shuffled_lcg_random_generator_unit_tb.sv
